FILE: hw/rtl/mie_pkg.sv
package mie_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned NREG = 32;
    localparam int unsigned RIDX_W = $clog2(NREG);
    localparam logic [XLEN-1:0] START_PC_RST = 32'h0040_0000;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_MISALIGN = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_UNEXPECT = 3'd4;

    localparam logic [2:0] LK_LB  = 3'd0;
    localparam logic [2:0] LK_LH  = 3'd1;
    localparam logic [2:0] LK_LW  = 3'd2;
    localparam logic [2:0] LK_LBU = 3'd3;
    localparam logic [2:0] LK_LHU = 3'd4;

    localparam logic [5:0] OP_RTYPE   = 6'd0;
    localparam logic [5:0] OP_BCOND   = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDI_U  = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTI_U  = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    localparam logic [4:0] RT_BLTZ      = 5'd0;
    localparam logic [4:0] RT_BGEZ      = 5'd1;
    localparam logic [4:0] RT_BLTZ_LINK = 5'd16;
    localparam logic [4:0] RT_BGEZ_LINK = 5'd17;

    // multiply/divide unit command
    typedef struct packed {
        logic            start;
        logic            is_div;
        logic            is_signed;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
    } md_cmd_t;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] hi;
        logic [XLEN-1:0] lo;
    } md_rsp_t;

endpackage

FILE: hw/rtl/mie_regfile.sv
module mie_regfile
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mie_pkg::RIDX_W-1:0] rd_addr_a,
    input  logic [mie_pkg::RIDX_W-1:0] rd_addr_b,
    output logic [mie_pkg::XLEN-1:0]   rd_data_a,
    output logic [mie_pkg::XLEN-1:0]   rd_data_b,
    input  logic                      wr_en,
    input  logic [mie_pkg::RIDX_W-1:0] wr_addr,
    input  logic [mie_pkg::XLEN-1:0]   wr_data
);
    import mie_pkg::*;

    logic [XLEN-1:0] mem_a [NREG];
    logic [XLEN-1:0] mem_b [NREG];
    logic [NREG-1:0] vld_reg;
    logic [XLEN-1:0] qa_reg;
    logic [XLEN-1:0] qb_reg;
    logic            va_reg;
    logic            vb_reg;

    // two copies give two read ports; write-first is not needed, writes never overlap reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
        qa_reg <= mem_a[rd_addr_a];
        qb_reg <= mem_b[rd_addr_b];
    end

    // r0 never gets a valid bit, so it always reads zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr != '0))
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            va_reg <= vld_reg[rd_addr_a];
            vb_reg <= vld_reg[rd_addr_b];
        end
    end

    assign rd_data_a = va_reg ? qa_reg : '0;
    assign rd_data_b = vb_reg ? qb_reg : '0;

endmodule

FILE: hw/rtl/mie_muldiv.sv
module mie_muldiv
(
    input  logic             clk,
    input  logic             rst_n,
    input  mie_pkg::md_cmd_t cmd,
    output mie_pkg::md_rsp_t rsp
);
    import mie_pkg::*;

    localparam int unsigned CNT_W = $clog2(XLEN + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic             nq_reg, nq_next;
    logic             nr_reg, nr_next;
    logic [XLEN-1:0]  a_reg, a_next;
    logic [XLEN-1:0]  b_reg, b_next;
    logic [XLEN-1:0]  acc_reg, acc_next;
    logic             done_reg, done_next;

    logic             na;
    logic             nb;
    logic [XLEN-1:0]  ma;
    logic [XLEN-1:0]  mb;
    logic [XLEN:0]    sum;
    logic [XLEN:0]    rem_sh;
    logic [XLEN:0]    diff;
    logic [XLEN-1:0]  q_fix;
    logic [XLEN-1:0]  r_fix;
    logic [XLEN-1:0]  p_hi;

    // shift-add multiply and restoring divide on magnitudes, one bit a cycle
    always_comb
    begin
        na     = cmd.is_signed & cmd.a[XLEN-1];
        nb     = cmd.is_signed & cmd.b[XLEN-1];
        ma     = na ? (~cmd.a + 1'b1) : cmd.a;
        mb     = nb ? (~cmd.b + 1'b1) : cmd.b;
        sum    = {1'b0, acc_reg} + ((a_reg[0]) ? {1'b0, b_reg} : '0);
        rem_sh = {acc_reg, a_reg[XLEN-1]};
        diff   = rem_sh - {1'b0, b_reg};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(XLEN);
            div_next  = cmd.is_div;
            nq_next   = na ^ nb;
            nr_next   = cmd.is_div ? na : (na ^ nb);
            a_next    = ma;
            b_next    = mb;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!diff[XLEN])
                begin
                    acc_next = diff[XLEN-1:0];
                    a_next   = {a_reg[XLEN-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[XLEN-1:0];
                    a_next   = {a_reg[XLEN-2:0], 1'b0};
                end
            end
            else
            begin
                acc_next = sum[XLEN:1];
                a_next   = {sum[0], a_reg[XLEN-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        nq_reg  <= nq_next;
        nr_reg  <= nr_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // sign fix-up: product negates as 64 bits, divide negates each half
    always_comb
    begin
        q_fix = nq_reg ? (~a_reg + 1'b1) : a_reg;
        r_fix = nr_reg ? (~acc_reg + 1'b1) : acc_reg;
        p_hi  = nr_reg ? (~acc_reg + ((a_reg == '0) ? 1'b1 : 1'b0)) : acc_reg;
        rsp.done = done_reg;
        if (div_reg)
        begin
            rsp.hi = r_fix;
            rsp.lo = q_fix;
        end
        else
        begin
            rsp.hi = p_hi;
            rsp.lo = q_fix;
        end
    end

endmodule

FILE: hw/rtl/mips_instruction_executor_unit.sv
// Sequence: an accepted item passes S_READ (registered register file read) and S_EXEC, then its
// result is registered; MULT/MULTU and nonzero-divisor DIV/DIVU wait in S_MD for the shared
// multiply/divide unit (one product or quotient bit per cycle). Only one item is held at a time;
// a new item is taken only in S_IDLE with the output drained.
// Reset: PC to the START_PC parameter, HI/LO zero, registers read zero, halt and pending load clear.
// No clearing pass: register file entries carry valid bits cleared by reset.
module mips_instruction_executor_unit
#(
    parameter logic [mie_pkg::XLEN-1:0] START_PC = mie_pkg::START_PC_RST
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mie_pkg::XLEN-1:0]   start_pc,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [mie_pkg::XLEN-1:0]   instr_word,
    input  logic [mie_pkg::XLEN-1:0]   load_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [mie_pkg::XLEN-1:0]   next_pc,
    output logic [1:0]                 mem_op,
    output logic [mie_pkg::XLEN-1:0]   mem_addr,
    output logic [mie_pkg::XLEN-1:0]   mem_wdata,
    output logic [3:0]                 mem_byte_mask,
    output logic                       reg_written,
    output logic [mie_pkg::RIDX_W-1:0] reg_index,
    output logic [mie_pkg::XLEN-1:0]   reg_value,
    output logic                       halted,
    output logic [2:0]                 status
);
    import mie_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_MD   = 4'b1000
    } state_t;

    state_t            st_reg, st_next;
    logic [XLEN-1:0]   pc_reg, pc_next;
    logic [XLEN-1:0]   hi_reg, hi_next;
    logic [XLEN-1:0]   lo_reg, lo_next;
    logic              halt_reg, halt_next;
    logic              lpend_reg, lpend_next;
    logic [RIDX_W-1:0] ltgt_reg, ltgt_next;
    logic [2:0]        lkind_reg, lkind_next;
    logic              req_reg;
    logic [XLEN-1:0]   iw_reg;
    logic [XLEN-1:0]   ld_reg;

    logic              ov_reg, ov_next;
    logic [XLEN-1:0]   o_npc_reg, o_npc_next;
    logic [1:0]        o_op_reg, o_op_next;
    logic [XLEN-1:0]   o_addr_reg, o_addr_next;
    logic [XLEN-1:0]   o_wd_reg, o_wd_next;
    logic [3:0]        o_bm_reg, o_bm_next;
    logic              o_rw_reg, o_rw_next;
    logic [RIDX_W-1:0] o_ri_reg, o_ri_next;
    logic [XLEN-1:0]   o_rv_reg, o_rv_next;
    logic              o_h_reg, o_h_next;
    logic [2:0]        o_st_reg, o_st_next;

    logic              in_acc;
    logic [XLEN-1:0]   ra;
    logic [XLEN-1:0]   rb;
    logic              wr_en;
    logic [RIDX_W-1:0] wr_idx;
    logic [XLEN-1:0]   wr_val;
    md_cmd_t           md_cmd;
    md_rsp_t           md_rsp;

    logic [5:0]        op;
    logic [5:0]        fn;
    logic [4:0]        rs;
    logic [4:0]        rt;
    logic [4:0]        rd;
    logic [4:0]        sh;
    logic [15:0]       imm;
    logic [XLEN-1:0]   simm;
    logic [XLEN-1:0]   pc4;
    logic [XLEN-1:0]   btgt;
    logic [XLEN-1:0]   addr;
    logic [XLEN-1:0]   npc;
    logic [2:0]        stat;
    logic [XLEN-1:0]   lv;
    logic              bad;

    assign op   = iw_reg[31:26];
    assign rs   = iw_reg[25:21];
    assign rt   = iw_reg[20:16];
    assign rd   = iw_reg[15:11];
    assign sh   = iw_reg[10:6];
    assign fn   = iw_reg[5:0];
    assign imm  = iw_reg[15:0];
    assign simm = {{(XLEN-16){imm[15]}}, imm};
    assign pc4  = pc_reg + XLEN'(4);
    assign btgt = pc4 + {simm[XLEN-3:0], 2'b00};
    assign addr = ra + simm;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (st_reg != S_IDLE) || (ov_reg && out_stall);
    assign cfg_ready = (st_reg == S_IDLE);

    // read addresses come from the held item word, read in S_READ
    mie_regfile u_rf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr_a (rs),
        .rd_addr_b (rt),
        .rd_data_a (ra),
        .rd_data_b (rb),
        .wr_en     (wr_en),
        .wr_addr   (wr_idx),
        .wr_data   (wr_val)
    );

    mie_muldiv u_md
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (md_cmd),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        unique case (lkind_reg)
            LK_LB:   lv = {{(XLEN-8){ld_reg[7]}}, ld_reg[7:0]};
            LK_LH:   lv = {{(XLEN-16){ld_reg[15]}}, ld_reg[15:0]};
            LK_LBU:  lv = {{(XLEN-8){1'b0}}, ld_reg[7:0]};
            LK_LHU:  lv = {{(XLEN-16){1'b0}}, ld_reg[15:0]};
            default: lv = ld_reg;
        endcase
    end

    always_comb
    begin
        st_next     = st_reg;
        pc_next     = pc_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        halt_next   = halt_reg;
        lpend_next  = lpend_reg;
        ltgt_next   = ltgt_reg;
        lkind_next  = lkind_reg;
        ov_next     = ov_reg && out_stall;
        o_npc_next  = o_npc_reg;
        o_op_next   = o_op_reg;
        o_addr_next = o_addr_reg;
        o_wd_next   = o_wd_reg;
        o_bm_next   = o_bm_reg;
        o_rw_next   = o_rw_reg;
        o_ri_next   = o_ri_reg;
        o_rv_next   = o_rv_reg;
        o_h_next    = o_h_reg;
        o_st_next   = o_st_reg;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_val      = '0;
        md_cmd      = '0;
        npc         = pc4;
        stat        = ST_OK;
        bad         = halt_reg || (req_reg ? !lpend_reg : lpend_reg);

        if (cfg_valid && cfg_ready)
        begin
            pc_next = {start_pc[XLEN-1:2], 2'b00};
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    st_next = S_READ;
                end
            end
            S_READ:
            begin
                st_next = S_EXEC;
            end
            S_EXEC:
            begin
                st_next     = S_IDLE;
                ov_next     = 1'b1;
                o_op_next   = MEM_NONE;
                o_addr_next = '0;
                o_wd_next   = '0;
                o_bm_next   = '0;
                if (bad)
                begin
                    npc  = pc_reg;
                    stat = ST_UNEXPECT;
                end
                else if (req_reg)
                begin
                    npc        = pc_reg;
                    wr_en      = 1'b1;
                    wr_idx     = ltgt_reg;
                    wr_val     = lv;
                    lpend_next = 1'b0;
                end
                else
                begin
                    priority case (op)
                        OP_RTYPE:
                        begin
                            wr_idx = rd;
                            priority case (fn)
                                FN_SLL:  begin wr_en = 1'b1; wr_val = rb << sh; end
                                FN_SRL:  begin wr_en = 1'b1; wr_val = rb >> sh; end
                                FN_SRA:  begin wr_en = 1'b1; wr_val = $signed(rb) >>> sh; end
                                FN_SLLV: begin wr_en = 1'b1; wr_val = rb << ra[4:0]; end
                                FN_SRLV: begin wr_en = 1'b1; wr_val = rb >> ra[4:0]; end
                                FN_SRAV:
                                begin
                                    wr_en  = 1'b1;
                                    wr_val = $signed(rb) >>> ra[4:0];
                                end
                                FN_JR, FN_JALR:
                                begin
                                    wr_en  = (fn == FN_JALR);
                                    wr_val = pc4;
                                    if (ra[1:0] == 2'b00)
                                    begin
                                        npc = ra;
                                    end
                                    else
                                    begin
                                        stat = ST_MISALIGN;
                                    end
                                end
                                FN_SYSCALL: halt_next = 1'b1;
                                FN_MFHI: begin wr_en = 1'b1; wr_val = hi_reg; end
                                FN_MTHI: hi_next = ra;
                                FN_MFLO: begin wr_en = 1'b1; wr_val = lo_reg; end
                                FN_MTLO: lo_next = ra;
                                FN_MULT, FN_MULTU:
                                begin
                                    md_cmd.start     = 1'b1;
                                    md_cmd.is_signed = (fn == FN_MULT);
                                    md_cmd.a         = ra;
                                    md_cmd.b         = rb;
                                    st_next          = S_MD;
                                    ov_next          = ov_reg && out_stall;
                                end
                                FN_DIV, FN_DIVU:
                                begin
                                    if (rb == '0)
                                    begin
                                        stat = ST_DIVZERO;
                                    end
                                    else
                                    begin
                                        md_cmd.start     = 1'b1;
                                        md_cmd.is_div    = 1'b1;
                                        md_cmd.is_signed = (fn == FN_DIV);
                                        md_cmd.a         = ra;
                                        md_cmd.b         = rb;
                                        st_next          = S_MD;
                                        ov_next          = ov_reg && out_stall;
                                    end
                                end
                                FN_ADD, FN_ADDU: begin wr_en = 1'b1; wr_val = ra + rb; end
                                FN_SUB, FN_SUBU: begin wr_en = 1'b1; wr_val = ra - rb; end
                                FN_AND:  begin wr_en = 1'b1; wr_val = ra & rb; end
                                FN_OR:   begin wr_en = 1'b1; wr_val = ra | rb; end
                                FN_XOR:  begin wr_en = 1'b1; wr_val = ra ^ rb; end
                                FN_NOR:  begin wr_en = 1'b1; wr_val = ~(ra | rb); end
                                FN_SLT:
                                begin
                                    wr_en  = 1'b1;
                                    wr_val = XLEN'($signed(ra) < $signed(rb));
                                end
                                FN_SLTU: begin wr_en = 1'b1; wr_val = XLEN'(ra < rb); end
                                default: begin stat = ST_UNKNOWN; npc = pc_reg; end
                            endcase
                        end
                        OP_BCOND:
                        begin
                            wr_idx = 5'd31;
                            wr_val = pc4;
                            priority case (rt)
                                RT_BLTZ: if (ra[XLEN-1]) npc = btgt;
                                RT_BGEZ: if (!ra[XLEN-1]) npc = btgt;
                                RT_BLTZ_LINK:
                                begin
                                    wr_en = 1'b1;
                                    if (ra[XLEN-1]) npc = btgt;
                                end
                                RT_BGEZ_LINK:
                                begin
                                    wr_en = 1'b1;
                                    if (!ra[XLEN-1]) npc = btgt;
                                end
                                default: begin stat = ST_UNKNOWN; npc = pc_reg; end
                            endcase
                        end
                        OP_J, OP_JAL:
                        begin
                            wr_en  = (op == OP_JAL);
                            wr_idx = 5'd31;
                            wr_val = pc4;
                            npc    = {pc4[31:28], iw_reg[25:0], 2'b00};
                        end
                        OP_BEQ:  if (ra == rb) npc = btgt;
                        OP_BNE:  if (ra != rb) npc = btgt;
                        OP_BLEZ: if ((ra == '0) || ra[XLEN-1]) npc = btgt;
                        OP_BGTZ: if ((ra != '0) && !ra[XLEN-1]) npc = btgt;
                        OP_ADDI, OP_ADDI_U:
                        begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = ra + simm;
                        end
                        OP_SLTI:
                        begin
                            wr_en  = 1'b1;
                            wr_idx = rt;
                            wr_val = XLEN'($signed(ra) < $signed(simm));
                        end
                        OP_SLTI_U:
                        begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = XLEN'(ra < simm);
                        end
                        OP_ANDI:
                        begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = ra & XLEN'(imm);
                        end
                        OP_ORI:
                        begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = ra | XLEN'(imm);
                        end
                        OP_XORI:
                        begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = ra ^ XLEN'(imm);
                        end
                        OP_LUI:
                        begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = {imm, 16'h0000};
                        end
                        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                        begin
                            lpend_next  = 1'b1;
                            ltgt_next   = rt;
                            priority case (op)
                                OP_LB:   lkind_next = LK_LB;
                                OP_LH:   lkind_next = LK_LH;
                                OP_LW:   lkind_next = LK_LW;
                                OP_LBU:  lkind_next = LK_LBU;
                                default: lkind_next = LK_LHU;
                            endcase
                            o_op_next   = MEM_READ;
                            o_addr_next = addr;
                        end
                        OP_SB, OP_SH, OP_SW:
                        begin
                            o_op_next   = MEM_WRITE;
                            o_addr_next = addr;
                            priority case (op)
                                OP_SB:
                                begin
                                    o_wd_next = {{(XLEN-8){1'b0}}, rb[7:0]};
                                    o_bm_next = 4'b0001;
                                end
                                OP_SH:
                                begin
                                    o_wd_next = {{(XLEN-16){1'b0}}, rb[15:0]};
                                    o_bm_next = 4'b0011;
                                end
                                default:
                                begin
                                    o_wd_next = rb;
                                    o_bm_next = 4'b1111;
                                end
                            endcase
                        end
                        default: begin stat = ST_UNKNOWN; npc = pc_reg; end
                    endcase
                    pc_next = npc;
                end
                if (wr_idx == '0)
                begin
                    wr_en = 1'b0;
                end
                o_npc_next = npc;
                o_rw_next  = wr_en;
                o_ri_next  = wr_en ? wr_idx : '0;
                o_rv_next  = wr_en ? wr_val : '0;
                o_h_next   = halt_next;
                o_st_next  = stat;
            end
            S_MD:
            begin
                if (md_rsp.done)
                begin
                    hi_next = md_rsp.hi;
                    lo_next = md_rsp.lo;
                    st_next = S_IDLE;
                    ov_next = 1'b1;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            pc_reg    <= START_PC;
            hi_reg    <= '0;
            lo_reg    <= '0;
            halt_reg  <= 1'b0;
            lpend_reg <= 1'b0;
            ltgt_reg  <= '0;
            lkind_reg <= LK_LB;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            pc_reg    <= pc_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            halt_reg  <= halt_next;
            lpend_reg <= lpend_next;
            ltgt_reg  <= ltgt_next;
            lkind_reg <= lkind_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= req_type;
            iw_reg  <= instr_word;
            ld_reg  <= load_data;
        end
        o_npc_reg  <= o_npc_next;
        o_op_reg   <= o_op_next;
        o_addr_reg <= o_addr_next;
        o_wd_reg   <= o_wd_next;
        o_bm_reg   <= o_bm_next;
        o_rw_reg   <= o_rw_next;
        o_ri_reg   <= o_ri_next;
        o_rv_reg   <= o_rv_next;
        o_h_reg    <= o_h_next;
        o_st_reg   <= o_st_next;
    end

    assign out_valid     = ov_reg;
    assign next_pc       = o_npc_reg;
    assign mem_op        = o_op_reg;
    assign mem_addr      = o_addr_reg;
    assign mem_wdata     = o_wd_reg;
    assign mem_byte_mask = o_bm_reg;
    assign reg_written   = o_rw_reg;
    assign reg_index     = o_ri_reg;
    assign reg_value     = o_rv_reg;
    assign halted        = o_h_reg;
    assign status        = o_st_reg;

endmodule

FILE: tb/sv/tb_mips_instruction_executor_unit.sv
module tb_mips_instruction_executor_unit;
    import mie_pkg::*;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [3:0]  mem_byte_mask;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        halted;
        logic [2:0]  status;
    } exec_res_t;

    class exec_scoreboard;
        logic [31:0] gpr [32];
        logic [31:0] hi_val, lo_val, pc, boot_pc;
        logic        halt, ld_pend;
        logic [4:0]  ld_tgt;
        logic [2:0]  ld_kind;
        exec_res_t   exp_q[$];
        int          mismatches, accepted, checked;

        function void reset_state();
            foreach (gpr[i]) gpr[i] = '0;
            hi_val = '0;
            lo_val = '0;
            boot_pc = START_PC_RST;
            pc = boot_pc;
            halt = 1'b0;
            ld_pend = 1'b0;
            ld_tgt = '0;
            ld_kind = LK_LB;
        endfunction

        function void set_start_pc(logic [31:0] v);
            boot_pc = {v[31:2], 2'b00};
            pc = boot_pc;
        endfunction

        function void wr_reg(inout exec_res_t r, input logic [4:0] idx, input logic [31:0] v);
            if (idx != 0)
            begin
                gpr[idx] = v;
                r.reg_written = 1'b1;
                r.reg_index = idx;
                r.reg_value = v;
            end
        endfunction

        function void note_input(logic rq, logic [31:0] iw, logic [31:0] ld);
            exec_res_t r;
            logic [31:0] pc4, npc, a, b, simm, btgt, v, ma, mb, q, rm;
            logic [63:0] p;
            logic [5:0]  op, fn;
            logic [4:0]  rs, rt, rd, sh;
            logic [2:0]  st;
            logic        na, nb;
            accepted++;
            r = '0;
            if (halt || (!rq && ld_pend) || (rq && !ld_pend))
            begin
                r.next_pc = pc;
                r.halted = halt;
                r.status = ST_UNEXPECT;
                exp_q.push_back(r);
                return;
            end
            if (rq)
            begin
                case (ld_kind)
                    LK_LB:   v = {{24{ld[7]}}, ld[7:0]};
                    LK_LH:   v = {{16{ld[15]}}, ld[15:0]};
                    LK_LBU:  v = {24'b0, ld[7:0]};
                    LK_LHU:  v = {16'b0, ld[15:0]};
                    default: v = ld;
                endcase
                wr_reg(r, ld_tgt, v);
                ld_pend = 1'b0;
                r.next_pc = pc;
                exp_q.push_back(r);
                return;
            end
            op = iw[31:26];
            rs = iw[25:21];
            rt = iw[20:16];
            rd = iw[15:11];
            sh = iw[10:6];
            fn = iw[5:0];
            simm = {{16{iw[15]}}, iw[15:0]};
            a = gpr[rs];
            b = gpr[rt];
            pc4 = pc + 4;
            npc = pc4;
            st = ST_OK;
            btgt = pc4 + (simm << 2);
            case (op)
                OP_RTYPE:
                    case (fn)
                        FN_SLL:  wr_reg(r, rd, b << sh);
                        FN_SRL:  wr_reg(r, rd, b >> sh);
                        FN_SRA:  wr_reg(r, rd, $signed(b) >>> sh);
                        FN_SLLV: wr_reg(r, rd, b << a[4:0]);
                        FN_SRLV: wr_reg(r, rd, b >> a[4:0]);
                        FN_SRAV: wr_reg(r, rd, $signed(b) >>> a[4:0]);
                        FN_JR, FN_JALR:
                        begin
                            if (fn == FN_JALR)
                                wr_reg(r, rd, pc4);
                            if (a[1:0] == 2'b00)
                                npc = a;
                            else
                                st = ST_MISALIGN;
                        end
                        FN_SYSCALL: halt = 1'b1;
                        FN_MFHI: wr_reg(r, rd, hi_val);
                        FN_MTHI: hi_val = a;
                        FN_MFLO: wr_reg(r, rd, lo_val);
                        FN_MTLO: lo_val = a;
                        FN_MULT, FN_MULTU:
                        begin
                            if (fn == FN_MULT)
                                p = longint'($signed(a)) * longint'($signed(b));
                            else
                                p = 64'(a) * 64'(b);
                            hi_val = p[63:32];
                            lo_val = p[31:0];
                        end
                        FN_DIV, FN_DIVU:
                        begin
                            if (b == 0)
                                st = ST_DIVZERO;
                            else if (fn == FN_DIVU)
                            begin
                                hi_val = a % b;
                                lo_val = a / b;
                            end
                            else
                            begin
                                na = a[31];
                                nb = b[31];
                                ma = na ? -a : a;
                                mb = nb ? -b : b;
                                q = ma / mb;
                                rm = ma % mb;
                                lo_val = (na != nb) ? -q : q;
                                hi_val = na ? -rm : rm;
                            end
                        end
                        FN_ADD, FN_ADDU: wr_reg(r, rd, a + b);
                        FN_SUB, FN_SUBU: wr_reg(r, rd, a - b);
                        FN_AND:  wr_reg(r, rd, a & b);
                        FN_OR:   wr_reg(r, rd, a | b);
                        FN_XOR:  wr_reg(r, rd, a ^ b);
                        FN_NOR:  wr_reg(r, rd, ~(a | b));
                        FN_SLT:  wr_reg(r, rd, {31'b0, $signed(a) < $signed(b)});
                        FN_SLTU: wr_reg(r, rd, {31'b0, a < b});
                        default:
                        begin
                            st = ST_UNKNOWN;
                            npc = pc;
                        end
                    endcase
                OP_BCOND:
                    case (rt)
                        RT_BLTZ: if (a[31]) npc = btgt;
                        RT_BGEZ: if (!a[31]) npc = btgt;
                        RT_BLTZ_LINK:
                        begin
                            wr_reg(r, 5'd31, pc4);
                            if (a[31]) npc = btgt;
                        end
                        RT_BGEZ_LINK:
                        begin
                            wr_reg(r, 5'd31, pc4);
                            if (!a[31]) npc = btgt;
                        end
                        default:
                        begin
                            st = ST_UNKNOWN;
                            npc = pc;
                        end
                    endcase
                OP_J, OP_JAL:
                begin
                    if (op == OP_JAL)
                        wr_reg(r, 5'd31, pc4);
                    npc = {pc4[31:28], iw[25:0], 2'b00};
                end
                OP_BEQ:  if (a == b) npc = btgt;
                OP_BNE:  if (a != b) npc = btgt;
                OP_BLEZ: if (a == 0 || a[31]) npc = btgt;
                OP_BGTZ: if (a != 0 && !a[31]) npc = btgt;
                OP_ADDI, OP_ADDI_U: wr_reg(r, rt, a + simm);
                OP_SLTI:   wr_reg(r, rt, {31'b0, $signed(a) < $signed(simm)});
                OP_SLTI_U: wr_reg(r, rt, {31'b0, a < simm});
                OP_ANDI:  wr_reg(r, rt, a & {16'b0, iw[15:0]});
                OP_ORI:   wr_reg(r, rt, a | {16'b0, iw[15:0]});
                OP_XORI:  wr_reg(r, rt, a ^ {16'b0, iw[15:0]});
                OP_LUI:   wr_reg(r, rt, {iw[15:0], 16'b0});
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    ld_pend = 1'b1;
                    ld_tgt = rt;
                    case (op)
                        OP_LB:   ld_kind = LK_LB;
                        OP_LH:   ld_kind = LK_LH;
                        OP_LW:   ld_kind = LK_LW;
                        OP_LBU:  ld_kind = LK_LBU;
                        default: ld_kind = LK_LHU;
                    endcase
                    r.mem_op = MEM_READ;
                    r.mem_addr = a + simm;
                end
                OP_SB, OP_SH, OP_SW:
                begin
                    r.mem_op = MEM_WRITE;
                    r.mem_addr = a + simm;
                    if (op == OP_SB)
                    begin
                        r.mem_wdata = {24'b0, b[7:0]};
                        r.mem_byte_mask = 4'd1;
                    end
                    else if (op == OP_SH)
                    begin
                        r.mem_wdata = {16'b0, b[15:0]};
                        r.mem_byte_mask = 4'd3;
                    end
                    else
                    begin
                        r.mem_wdata = b;
                        r.mem_byte_mask = 4'd15;
                    end
                end
                default:
                begin
                    st = ST_UNKNOWN;
                    npc = pc;
                end
            endcase
            pc = npc;
            r.next_pc = npc;
            r.halted = halt;
            r.status = st;
            exp_q.push_back(r);
        endfunction

        function void cmp(string fname, logic [31:0] e, logic [31:0] act);
            if (e !== act)
            begin
                $error("%s: expected %h, got %h", fname, e, act);
                mismatches++;
            end
        endfunction

        function void check_result(exec_res_t got);
            exec_res_t e;
            if (exp_q.size() == 0)
            begin
                $error("result with nothing expected: next_pc %h", got.next_pc);
                mismatches++;
                return;
            end
            e = exp_q.pop_front();
            checked++;
            cmp("next_pc", e.next_pc, got.next_pc);
            cmp("mem_op", e.mem_op, got.mem_op);
            cmp("mem_addr", e.mem_addr, got.mem_addr);
            cmp("mem_wdata", e.mem_wdata, got.mem_wdata);
            cmp("mem_byte_mask", e.mem_byte_mask, got.mem_byte_mask);
            cmp("reg_written", e.reg_written, got.reg_written);
            cmp("reg_index", e.reg_index, got.reg_index);
            cmp("reg_value", e.reg_value, got.reg_value);
            cmp("halted", e.halted, got.halted);
            cmp("status", e.status, got.status);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] start_pc = START_PC_RST;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [31:0] instr_word = '0;
    logic [31:0] load_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] next_pc, mem_addr, mem_wdata, reg_value;
    logic [1:0]  mem_op;
    logic [3:0]  mem_byte_mask;
    logic        reg_written, halted;
    logic [4:0]  reg_index;
    logic [2:0]  status;

    exec_scoreboard sb = new();
    int  burst_left = 0;
    bit  hold_req = 1'b0;
    bit  gen_pending = 1'b0;

    mips_instruction_executor_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .start_pc(start_pc),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .instr_word(instr_word), .load_data(load_data),
        .out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
        .mem_op(mem_op), .mem_addr(mem_addr), .mem_wdata(mem_wdata),
        .mem_byte_mask(mem_byte_mask), .reg_written(reg_written),
        .reg_index(reg_index), .reg_value(reg_value), .halted(halted),
        .status(status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(req_type, instr_word, load_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_result({next_pc, mem_op, mem_addr, mem_wdata, mem_byte_mask,
                             reg_written, reg_index, reg_value, halted, status});
    end

    // receiver: stall pattern drawn from four random modes; long hold on request
    initial
    begin
        int cyc;
        int mode;
        int hold_cnt;
        cyc = 0;
        mode = 0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_req && hold_cnt == 0)
            begin
                hold_req = 1'b0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 4) != 0);
                    default: out_stall <= cyc[2];
                endcase
        end
    end

    function automatic logic [31:0] rtype(int rs, int rt, int rd, int sh, logic [5:0] fn);
        return {OP_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, logic [15:0] imm);
        return {op, 5'(rs), 5'(rt), imm};
    endfunction

    function automatic int pick_reg();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
    endfunction

    task automatic send_item(logic rq, logic [31:0] iw, logic [31:0] ld);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= rq;
        instr_word <= iw;
        load_data <= ld;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic quiesce();
        if (in_valid)
            in_valid <= 1'b0;
        burst_left = 0;
        while (sb.exp_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_start_pc(logic [31:0] v);
        cfg_valid <= 1'b1;
        start_pc <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_start_pc(v);
    endtask

    task automatic send_insn(logic [31:0] iw);
        send_item(1'b0, iw, $urandom());
    endtask

    task automatic send_ld(logic [31:0] ld);
        send_item(1'b1, $urandom(), ld);
    endtask

    task automatic run_directed();
        send_insn(itype(OP_LUI, 0, 1, 16'h8000));
        send_insn(itype(OP_ADDI_U, 0, 2, 16'hFFFF));
        send_insn(rtype(1, 2, 0, 0, FN_DIV));
        send_insn(rtype(0, 0, 3, 0, FN_MFLO));
        send_insn(rtype(0, 0, 4, 0, FN_MFHI));
        send_insn(rtype(1, 0, 0, 0, FN_DIV));
        send_insn(rtype(1, 2, 0, 0, FN_MULT));
        send_insn(rtype(2, 2, 0, 0, FN_MULTU));
        send_insn(rtype(0, 0, 5, 0, FN_NOR));
        send_insn(rtype(2, 2, 0, 0, FN_ADDU));
        send_insn(rtype(1, 0, 9, 31, FN_SRA));
        send_insn(rtype(2, 0, 0, 0, FN_JR));
        send_insn(rtype(2, 0, 6, 0, FN_JALR));
        send_insn(itype(OP_LW, 1, 7, 16'hFFFC));
        send_ld(32'hFFFF_FFFF);
        send_ld(32'h0000_0000);
        send_insn(itype(OP_LB, 2, 8, 16'h0000));
        send_insn(itype(OP_ADDI_U, 0, 3, 16'h0001));
        send_ld(32'h0000_FF80);
        send_insn(itype(OP_SB, 0, 2, 16'h7FFF));
        send_insn(itype(OP_SH, 2, 1, 16'h8000));
        send_insn(itype(OP_SW, 1, 2, 16'h0004));
        send_insn(itype(OP_BCOND, 0, RT_BLTZ_LINK, 16'h0010));
        send_insn(itype(OP_BCOND, 1, RT_BGEZ_LINK, 16'hFFF0));
        send_insn({OP_JAL, 26'h3FF_FFFF});
        send_insn({6'h3F, 26'h155_5555});
        send_insn(itype(OP_BCOND, 0, 2, 16'h0000));
    endtask

    task automatic random_item();
        logic [5:0] fns[20] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
                                FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_ADD, FN_ADDU,
                                FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
                                FN_SLT, FN_SLTU};
        logic [5:0] iops[8] = '{OP_ADDI, OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI,
                                OP_ORI, OP_XORI, OP_LUI};
        logic [5:0] lops[5] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
        logic [5:0] sops[3] = '{OP_SB, OP_SH, OP_SW};
        logic [5:0] bops[4] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
        logic [4:0] rts[4] = '{RT_BLTZ, RT_BGEZ, RT_BLTZ_LINK, RT_BGEZ_LINK};
        logic [5:0] mds[4] = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU};
        logic [31:0] w;
        int k;
        k = $urandom_range(0, 99);
        if (gen_pending)
        begin
            if (k < 90)
            begin
                send_ld($urandom());
                gen_pending = 1'b0;
            end
            else
                send_insn($urandom());
            return;
        end
        if (k < 4)
            send_ld($urandom());
        else if (k < 30)
            send_insn(rtype(pick_reg(), pick_reg(), pick_reg(), $urandom_range(0, 31),
                            fns[$urandom_range(0, 19)]));
        else if (k < 52)
            send_insn(itype(iops[$urandom_range(0, 7)], pick_reg(), pick_reg(),
                            16'($urandom())));
        else if (k < 58)
            send_insn(rtype(pick_reg(), pick_reg(), 0, 0, mds[$urandom_range(0, 3)]));
        else if (k < 68)
        begin
            send_insn(itype(lops[$urandom_range(0, 4)], pick_reg(), pick_reg(),
                            16'($urandom())));
            gen_pending = 1'b1;
        end
        else if (k < 75)
            send_insn(itype(sops[$urandom_range(0, 2)], pick_reg(), pick_reg(),
                            16'($urandom())));
        else if (k < 82)
            send_insn(itype(bops[$urandom_range(0, 3)], pick_reg(), pick_reg(),
                            16'($urandom())));
        else if (k < 86)
            send_insn(itype(OP_BCOND, pick_reg(), rts[$urandom_range(0, 3)],
                            16'($urandom())));
        else if (k < 90)
            send_insn({($urandom_range(0, 1) ? OP_JAL : OP_J), 26'($urandom())});
        else if (k < 94)
            send_insn(rtype(pick_reg(), 0, pick_reg(), 0,
                            $urandom_range(0, 1) ? FN_JALR : FN_JR));
        else
        begin
            w = $urandom();
            if (w[31:26] == OP_RTYPE && w[5:0] == FN_SYSCALL)
                w[0] = 1'b1;
            if (w[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU})
                gen_pending = 1'b1;
            send_insn(w);
        end
    endtask

    initial
    begin
        logic [31:0] pcs[5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0040_0000,
                                32'h8000_0002, 32'h1234_5678};
        sb.reset_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        gen_pending = 1'b0;
        for (int ph = 0; ph < 5; ph++)
        begin
            quiesce();
            write_start_pc(ph == 4 ? $urandom() : pcs[ph]);
            for (int i = 0; i < 185; i++)
            begin
                if (ph == 1 && i == 60)
                    hold_req = 1'b1;
                if (ph == 2 && i == 90)
                    quiesce();
                random_item();
            end
        end
        send_insn(rtype(0, 0, 0, 0, FN_SYSCALL));
        send_insn(itype(OP_ADDI_U, 0, 1, 16'h0001));
        send_ld(32'h1);
        in_valid <= 1'b0;
        quiesce();
        $display("Ran %0d items over 5 start_pc settings; %0d results checked, %0d mismatches.",
                 sb.accepted, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.exp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: mips_instruction_executor_unit.f
hw/rtl/mie_pkg.sv
hw/rtl/mie_regfile.sv
hw/rtl/mie_muldiv.sv
hw/rtl/mips_instruction_executor_unit.sv
tb/sv/tb_mips_instruction_executor_unit.sv
